>>> design/htfe_pkg.sv
// shared types and constants for the header/trailer frame extractor
package htfe_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER = 1'd1;

  // register reset values
  localparam logic [BYTE_W-1:0] HEADER_RST  = 8'hFF;
  localparam logic [BYTE_W-1:0] TRAILER_RST = 8'hEE;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } htfe_state_t;

endpackage

>>> design/htfe_if.sv
// valid/ready channel interfaces for input bytes and frame bytes
interface htfe_in_if;
  import htfe_pkg::*;
  logic  valid;
  logic  ready;
  byte_t rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface htfe_out_if;
  import htfe_pkg::*;
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  frame_end;
  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

>>> design/header_trailer_frame_extractor_top.sv
// top level of the header/trailer byte frame extractor
// usage:
// - in_ch carries received bytes, one per beat; every byte is stored in a
//   DEPTH-entry ring and the write position advances and wraps
// - a byte equal to the header register marks its own slot as frame start
// - a byte equal to the trailer register, while the start slot still holds
//   the header value, closes a frame: the bytes from header through trailer
//   are sent on out_ch, frame_end high on the trailer beat, and the ring
//   positions go back to zero
// - cfg port: cfg_we writes cfg_data to register cfg_idx (0 header, 1 trailer)
// timing:
// - a byte that closes no frame leaves the block idle, with in_ch still ready
// - readout goes through the single registered read port of the ring; each
//   frame byte is read in ST_READ and then loaded into the output register in
//   ST_LOAD, starting once the trailer beat is taken
// - in_ch is not ready during readout; it reopens once the last read is loaded,
//   while the trailer beat may still wait in the output register
// - a stalled out_ch holds the output register and pauses the readout
// reset: synchronous rst_n clears write/start positions and handshake state,
// restores header (0xff) and trailer (0xee); ring contents need no clearing
module header_trailer_frame_extractor_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  htfe_in_if.sink                        in_ch,
  htfe_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [htfe_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [htfe_pkg::CFG_W-1:0]     cfg_data
);
  import htfe_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);

  // ring store access
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  byte_t            ram_wdata, ram_rdata;

  // sequencer: positions, frame detection, output register
  htfe_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_byte   (in_ch.rx_byte),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_end   (out_ch.frame_end),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // byte ring, written on every input beat, read during frame readout
  htfe_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> design/htfe_ram.sv
// byte ring store: one write port, one registered read port
module htfe_ram #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  htfe_pkg::byte_t          wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output htfe_pkg::byte_t          rdata
);
  import htfe_pkg::*;

  byte_t mem [DEPTH];
  byte_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/htfe_ctrl.sv
// index tracking, frame detection and readout sequencer
module htfe_ctrl #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [htfe_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [htfe_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  htfe_pkg::byte_t            in_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output htfe_pkg::byte_t            out_byte,
  output logic                       out_end,
  output logic                       ram_we,
  output logic [$clog2(DEPTH)-1:0]   ram_waddr,
  output htfe_pkg::byte_t            ram_wdata,
  output logic                       ram_re,
  output logic [$clog2(DEPTH)-1:0]   ram_raddr,
  input  htfe_pkg::byte_t            ram_rdata
);
  import htfe_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  htfe_state_t      state_r, state_nxt;
  byte_t            header_r, trailer_r;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] start_idx_r, start_idx_nxt;
  byte_t            start_byte_r, start_byte_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] end_r, end_nxt;
  logic             last_rd_r, last_rd_nxt;
  logic             out_valid_r, out_valid_nxt;
  byte_t            out_byte_r, out_byte_nxt;
  logic             out_end_r, out_end_nxt;

  logic             in_acc, hdr_hit, trl_hit, frame_hit, out_free, load_out;
  logic [IDX_W-1:0] wr_inc, pos_inc, start_sel;
  byte_t            start_byte_sel;

  assign in_acc   = in_valid && in_ready;
  assign hdr_hit  = (in_byte == header_r);
  assign trl_hit  = (in_byte == trailer_r);
  assign wr_inc   = (wr_idx_r == IDX_LAST) ? '0 : wr_idx_r + IDX_ONE;
  assign pos_inc  = (pos_r == IDX_LAST) ? '0 : pos_r + IDX_ONE;
  assign out_free = !out_valid_r || out_ready;

  // byte held at start position once this beat is stored
  assign start_sel      = hdr_hit ? wr_idx_r : start_idx_r;
  assign start_byte_sel = (hdr_hit || (wr_idx_r == start_idx_r)) ? in_byte : start_byte_r;
  assign frame_hit      = trl_hit && (start_byte_sel == header_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && frame_hit) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (out_free) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = last_rd_r ? ST_IDLE : ST_READ;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready = 1'b0;
    ram_re   = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_READ: ram_re   = out_free;
      ST_LOAD: load_out = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  assign ram_we    = in_acc;
  assign ram_waddr = wr_idx_r;
  assign ram_wdata = in_byte;
  assign ram_raddr = pos_r;

  // datapath
  always_comb begin
    wr_idx_nxt     = wr_idx_r;
    start_idx_nxt  = start_idx_r;
    start_byte_nxt = start_byte_r;
    pos_nxt        = pos_r;
    end_nxt        = end_r;
    last_rd_nxt    = last_rd_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_byte_nxt   = out_byte_r;
    out_end_nxt    = out_end_r;
    if (in_acc) begin
      if (frame_hit) begin
        pos_nxt       = start_sel;
        end_nxt       = wr_idx_r;
        wr_idx_nxt    = '0;
        start_idx_nxt = '0;
      end else begin
        wr_idx_nxt    = wr_inc;
        start_idx_nxt = start_sel;
      end
      start_byte_nxt = start_byte_sel;
    end
    if (ram_re) begin
      pos_nxt     = pos_inc;
      last_rd_nxt = (pos_r == end_r);
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = ram_rdata;
      out_end_nxt   = last_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      header_r    <= HEADER_RST;
      trailer_r   <= TRAILER_RST;
      wr_idx_r    <= '0;
      start_idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      start_idx_r <= start_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_idx == REG_HEADER)) begin
        header_r <= cfg_data;
      end
      if (cfg_we && (cfg_idx == REG_TRAILER)) begin
        trailer_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    start_byte_r <= start_byte_nxt;
    pos_r        <= pos_nxt;
    end_r        <= end_nxt;
    last_rd_r    <= last_rd_nxt;
    out_byte_r   <= out_byte_nxt;
    out_end_r    <= out_end_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_end   = out_end_r;

endmodule

>>> tb/sv/header_trailer_frame_extractor_top_tb.sv
// self-checking testbench for the header/trailer frame extractor top level
module header_trailer_frame_extractor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import htfe_pkg::*;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned PTR_W        = $clog2(DEPTH);
  localparam int unsigned PHASE_ITEMS  = 70;
  // drain after idle; a byte that closes no frame needs no readout, so this covers it
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);

  // one expected beat of an extracted frame
  typedef struct packed {
    byte_t data;
    logic  frame_end;
  } frame_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  htfe_in_if  in_ch ();
  htfe_out_if out_ch ();

  header_trailer_frame_extractor_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bytes waiting to be sent, and frame beats the ring should give back
  byte_t       pending_bytes[$];
  frame_beat_t frame_beats_due[$];

  // mirror of the ring and its positions, plus the two match values
  byte_t            ring [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] start_ptr;
  byte_t            hdr_val;
  byte_t            trl_val;

  int unsigned errors      = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left;
  int unsigned gap_left;
  logic [15:0] stall_pat;
  logic [3:0]  pat_pos;

  // store one byte in the ring mirror; if it closes a frame, queue the whole
  // header..trailer run and return both positions to zero
  task automatic ring_accept_byte(input byte_t b);
    logic [PTR_W-1:0] slot;
    logic [PTR_W-1:0] pos;
    int               span;
    slot       = wr_ptr;
    ring[slot] = b;
    wr_ptr     = (slot == PTR_W'(DEPTH - 1)) ? '0 : slot + PTR_ONE;
    // a later header simply moves the frame start
    if (b == hdr_val) start_ptr = slot;
    // the start slot may have been overwritten by a wrapped overlong frame
    if (ring[start_ptr] == hdr_val && b == trl_val) begin
      span = (int'(slot) + DEPTH - int'(start_ptr)) % DEPTH;
      pos  = start_ptr;
      for (int k = 0; k <= span; k++) begin
        frame_beats_due.push_back(frame_beat_t'{data: ring[pos], frame_end: (k == span)});
        pos = (pos == PTR_W'(DEPTH - 1)) ? '0 : pos + PTR_ONE;
      end
      wr_ptr    = '0;
      start_ptr = '0;
    end
  endtask

  // a byte that matches neither the header nor the trailer value
  function automatic byte_t plain_byte();
    byte_t b;
    do b = byte_t'($urandom_range(0, 255)); while (b == hdr_val || b == trl_val);
    return b;
  endfunction

  // random traffic: mostly well-formed frames with random payload, the rest
  // line noise, unterminated headers, stray trailers and ring overruns
  task automatic queue_traffic(input int unsigned n);
    int unsigned base;
    int unsigned kind;
    int unsigned len;
    int unsigned tier;
    base = pending_bytes.size();
    while (pending_bytes.size() - base < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // mostly short frames, a few long ones up to a full ring
        tier = $urandom_range(0, 99);
        if (tier < 80) len = $urandom_range(0, 6);
        else if (tier < 95) len = $urandom_range(7, 30);
        else len = $urandom_range(31, DEPTH - 2);
        pending_bytes.push_back(hdr_val);
        repeat (len) begin
          // now and then a payload byte restarts or closes the frame early
          if ($urandom_range(0, 9) == 0) pending_bytes.push_back(byte_t'($urandom_range(0, 255)));
          else pending_bytes.push_back(plain_byte());
        end
        pending_bytes.push_back(trl_val);
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 4)) pending_bytes.push_back(byte_t'($urandom_range(0, 255)));
      end else if (kind < 88) begin
        // header with no trailer yet
        pending_bytes.push_back(hdr_val);
        repeat ($urandom_range(0, 5)) pending_bytes.push_back(plain_byte());
      end else if (kind < 97) begin
        pending_bytes.push_back(trl_val);
      end else begin
        // overlong frame: the ring wraps onto the header before the trailer
        pending_bytes.push_back(hdr_val);
        repeat ($urandom_range(DEPTH - 1, DEPTH + 1)) pending_bytes.push_back(plain_byte());
        pending_bytes.push_back(trl_val);
      end
    end
  endtask

  // block is idle once every byte is taken and every frame beat has arrived;
  // sampled at the falling edge so the clocked blocks have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_bytes.size() != 0 || in_ch.valid || frame_beats_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // both registers written on back-to-back edges, only while idle
  task automatic set_regs(input byte_t hdr, input byte_t trl);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_HEADER;
    cfg_data <= hdr;
    @(posedge clk);
    cfg_idx  <= REG_TRAILER;
    cfg_data <= trl;
    @(posedge clk);
    cfg_we   <= 1'b0;
    hdr_val = hdr;
    trl_val = trl;
  endtask

  // sender: bursts of random length with random gaps, fed from pending_bytes
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) ring_accept_byte(in_ch.rx_byte);
      // a beat on offer is held until it is taken
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_ch.valid   <= 1'b1;
          in_ch.rx_byte <= pending_bytes.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // occasional long bursts give stretches with no idling at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: ready follows a 16-bit stall pattern, reloaded every pass;
  // a quarter of the patterns never stall
  always @(posedge clk) begin
    frame_beat_t due;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_pat    <= 16'hffff;
      pat_pos      <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (frame_beats_due.size() == 0) begin
          $error("unexpected beat: out_byte %0h frame_end %0b",
                 out_ch.out_byte, out_ch.frame_end);
          errors++;
        end else begin
          due = frame_beats_due.pop_front();
          if (out_ch.out_byte !== due.data) begin
            $error("out_byte mismatch: expected %0h, actual %0h", due.data, out_ch.out_byte);
            errors++;
          end
          if (out_ch.frame_end !== due.frame_end) begin
            $error("frame_end mismatch: expected %0b, actual %0b",
                   due.frame_end, out_ch.frame_end);
            errors++;
          end
        end
      end
      out_ch.ready <= stall_pat[pat_pos];
      pat_pos      <= pat_pos + 4'd1;
      if (pat_pos == 4'hf)
        stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom()) | 16'h0101);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    byte_t h;
    byte_t t;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_HEADER;
    cfg_data      = '0;
    rst_n         = 1'b0;
    hdr_val       = HEADER_RST;
    trl_val       = TRAILER_RST;
    wr_ptr        = '0;
    start_ptr     = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset match values: plain frame, bare header+trailer,
    // trailer with no header, header replaced by a later one, trailing noise
    pending_bytes = {8'hFF, 8'h00, 8'hEE,
                     8'hFF, 8'hEE,
                     8'hEE,
                     8'h12, 8'hFF, 8'h34, 8'hFF, 8'h56, 8'hEE,
                     8'h01, 8'hFE, 8'h7F, 8'h80};
    wait_idle();

    // header equal to trailer: every such byte is a one-byte frame
    set_regs(8'h5A, 8'h5A);
    pending_bytes = {8'h5A, 8'h00, 8'h5A, 8'hA5};
    wait_idle();

    // random phases over extreme, equal and random match values
    set_regs(8'h00, 8'hFF);
    queue_traffic(PHASE_ITEMS);
    wait_idle();

    set_regs(8'hFF, 8'h00);
    queue_traffic(PHASE_ITEMS);
    wait_idle();

    h = byte_t'($urandom_range(0, 255));
    set_regs(h, h);
    queue_traffic(PHASE_ITEMS);
    wait_idle();

    h = byte_t'($urandom_range(0, 255));
    do t = byte_t'($urandom_range(0, 255)); while (t == h);
    set_regs(h, t);
    queue_traffic(PHASE_ITEMS);
    wait_idle();

    set_regs(HEADER_RST, TRAILER_RST);
    queue_traffic(PHASE_ITEMS);
    wait_idle();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
design/htfe_pkg.sv
design/htfe_if.sv
design/htfe_ram.sv
design/htfe_ctrl.sv
design/header_trailer_frame_extractor_top.sv
tb/sv/header_trailer_frame_extractor_top_tb.sv
